// File: rtl/phvd_pkg.sv
// Shared constants, types and field positions of the piezo hit velocity detector.
package phvd_pkg;

  // Deepest averaging window the history memory holds.
  localparam int MAX_WINDOW = 128;
  localparam int HIST_AW    = $clog2(MAX_WINDOW);
  localparam int FILL_W     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W      = 15 + HIST_AW;
  localparam int WCMP_W     = (FILL_W > 8) ? FILL_W : 8;

  // Shared multiplier and divider widths.
  localparam int MUL_AW  = 31;
  localparam int MUL_BW  = 16;
  localparam int PROD_W  = 47;
  localparam int DIV_NW  = 31;
  localparam int DIV_DW  = 16;
  localparam int DIV_QW  = 15;
  localparam int DIV_CW  = $clog2(DIV_QW + 1);

  // Configuration register indexes.
  localparam logic [2:0] REG_ADC_OFFSET   = 3'd0;
  localparam logic [2:0] REG_INPUT_GAIN   = 3'd1;
  localparam logic [2:0] REG_THR_MARGIN   = 3'd2;
  localparam logic [2:0] REG_AVG_WINDOW   = 3'd3;
  localparam logic [2:0] REG_PEAK_SPAN    = 3'd4;
  localparam logic [2:0] REG_RELEASE_TIME = 3'd5;
  localparam logic [2:0] REG_VEL_GAIN     = 3'd6;
  localparam logic [2:0] REG_LOUD_LEVEL   = 3'd7;

  // Reset values of the configuration registers.
  localparam logic [15:0] RST_ADC_OFFSET   = 16'd27643;
  localparam logic [15:0] RST_INPUT_GAIN   = 16'd27197;
  localparam logic [14:0] RST_THR_MARGIN   = 15'd1638;
  localparam logic [7:0]  RST_AVG_WINDOW   = 8'd100;
  localparam logic [7:0]  RST_PEAK_SPAN    = 8'd50;
  localparam logic [15:0] RST_RELEASE_TIME = 16'd500;
  localparam logic [15:0] RST_VEL_GAIN     = 16'd500;
  localparam logic [14:0] RST_LOUD_LEVEL   = 15'd29491;

  // Phase codes reported on the result stream.
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_TRIG = 2'd1;
  localparam logic [1:0] PH_REL  = 2'd2;

  // Result tdata layout, lowest bit first.
  localparam int VEL_LSB   = 0;
  localparam int LOUD_BIT  = 15;
  localparam int THR_LSB   = 16;
  localparam int COND_LSB  = 32;
  localparam int PHASE_LSB = 48;
  localparam int OUT_DW    = 56;

  localparam logic [14:0] VEL_FULL = 15'h7FFF;

  typedef struct packed {
    logic signed [MUL_AW-1:0] a;
    logic        [MUL_BW-1:0] b;
  } mul_op_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_QW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        push;
    logic [14:0] mag;
    logic [7:0]  window;
  } hist_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] sum;
  } hist_rsp_t;

endpackage

// File: rtl/piezo_hit_velocity_detector.sv
// Top level of the piezo hit velocity detector: sequencer, detector and stream ports.
//
//   Channel  | Direction | Handshake           | Payload
//   ---------+-----------+---------------------+----------------------------------------
//   in_      | sink      | in_tvalid/in_tready | in_tdata: raw_sample
//   out_     | source    | out_tvalid/tready   | out_tuser: hit; out_tdata: velocity, loud,
//            |           |                     |   threshold, conditioned, phase
//   cfg_     | sink      | cfg_we (no wait)    | cfg_addr: register index; cfg_wdata
//
// Each request sums N = min(samples seen, window) history entries, one per cycle
// through the single memory read port, and then takes a pass through the shared
// divider. A request that reports a hit may add the velocity products and a second
// pass through the divider.
// Reset is synchronous and active low; it restores the configuration registers,
// empties the history (through its fill count) and returns the detector to waiting.
// in_tready is high only while the sequencer is idle. A finished result sits in the
// output register until it is taken, and the next request may be accepted meanwhile;
// that request then waits at its final step until the output register is free.
module piezo_hit_velocity_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input request stream.
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,    // [15:0] raw_sample
  // Result stream.
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [phvd_pkg::OUT_DW-1:0]   out_tdata,   // [14:0] velocity, [15] loud,
                                                     // [31:16] threshold,
                                                     // [47:32] conditioned,
                                                     // [49:48] phase, [55:50] zero
  output logic                          out_tuser,   // [0] hit
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_addr,
  input  logic [15:0]                   cfg_wdata
);

  // Sequencer steps.
  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_MCOND = 12'b0000_0000_0010,
    S_COND  = 12'b0000_0000_0100,
    S_SUM   = 12'b0000_0000_1000,
    S_ADIV  = 12'b0000_0001_0000,
    S_DET   = 12'b0000_0010_0000,
    S_MDD   = 12'b0000_0100_0000,
    S_MVG   = 12'b0000_1000_0000,
    S_MPP   = 12'b0001_0000_0000,
    S_VCHK  = 12'b0010_0000_0000,
    S_VDIV  = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } seq_t;

  // Detector phase.
  typedef enum logic [2:0] {
    DET_WAIT = 3'b001,
    DET_TRIG = 3'b010,
    DET_REL  = 3'b100
  } det_t;

  seq_t state_r;
  det_t det_r;
  det_t det_nxt;

  // Configuration registers.
  logic [15:0] adc_offset_r;
  logic [15:0] input_gain_r;
  logic [14:0] thr_margin_r;
  logic [7:0]  avg_window_r;
  logic [7:0]  peak_span_r;
  logic [15:0] release_time_r;
  logic [15:0] vel_gain_r;
  logic [14:0] loud_level_r;

  // Per-request working registers.
  logic [15:0]        raw_r;
  logic signed [15:0] x_r;
  logic signed [15:0] thr_r;
  logic [14:0]        vel_r;
  logic               hit_r;
  logic [30:0]        n2_r;

  // Detector registers.
  logic signed [15:0] trip_r;
  logic signed [15:0] trip_nxt;
  logic signed [15:0] peak_r;
  logic signed [15:0] peak_nxt;
  logic [7:0]         pos_r;
  logic [7:0]         pos_nxt;
  logic [7:0]         span_r;
  logic [7:0]         span_nxt;
  logic [15:0]        hold_r;
  logic [15:0]        hold_nxt;
  logic               hit_nxt;

  // Output register.
  logic                        out_tvalid_r;
  logic                        out_tuser_r;
  logic [phvd_pkg::OUT_DW-1:0] out_tdata_r;

  // Shared units.
  phvd_pkg::mul_op_t                  mul_op;
  logic signed [phvd_pkg::PROD_W-1:0] prod_r;
  phvd_pkg::div_req_t                 div_req;
  phvd_pkg::div_rsp_t                 div_rsp;
  phvd_pkg::hist_req_t                hist_req;
  phvd_pkg::hist_rsp_t                hist_rsp;

  // Datapath terms.
  logic signed [16:0]                 diff_c;
  logic signed [phvd_pkg::PROD_W-1:0] rnd_c;
  logic signed [phvd_pkg::PROD_W-1:0] shf_c;
  logic signed [15:0]                 x_c;
  logic [15:0]                        x_neg;
  logic [14:0]                        mag_c;
  logic signed [16:0]                 thr_wide;
  logic signed [15:0]                 thr_c;
  logic [15:0]                        dist_c;
  logic                               vel_sat;
  logic                               out_free;
  logic                               loud_c;
  logic [1:0]                         phase_c;

  phvd_mul u_mul (
    .clk    (clk),
    .op     (mul_op),
    .prod_r (prod_r)
  );

  phvd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  phvd_hist u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hist_req),
    .rsp   (hist_rsp)
  );

  // Conditioning: offset, gain in unsigned Q1.15, round half up to Q1.15 and saturate.
  always_comb begin
    diff_c = $signed({1'b0, raw_r}) - $signed({1'b0, adc_offset_r});
    rnd_c  = prod_r + phvd_pkg::PROD_W'(16384);
    shf_c  = rnd_c >>> 15;
    if (shf_c > phvd_pkg::PROD_W'(32767)) begin
      x_c = 16'sh7FFF;
    end else if (shf_c < -phvd_pkg::PROD_W'(32768)) begin
      x_c = -16'sh8000;
    end else begin
      x_c = shf_c[15:0];
    end
    // The magnitude of the most negative code saturates to the largest positive one.
    x_neg = 16'd0 - x_c;
    if (x_c == -16'sh8000) begin
      mag_c = 15'h7FFF;
    end else if (x_c[15]) begin
      mag_c = x_neg[14:0];
    end else begin
      mag_c = x_c[14:0];
    end
  end

  // Threshold from the average held in the divider quotient.
  always_comb begin
    thr_wide = -$signed({2'b00, div_rsp.quot}) - $signed({2'b00, thr_margin_r});
    if (thr_wide < -17'sd32768) begin
      thr_c = -16'sh8000;
    end else begin
      thr_c = thr_wide[15:0];
    end
  end

  // Detector update for the current sample.
  always_comb begin
    det_nxt  = det_r;
    trip_nxt = trip_r;
    peak_nxt = peak_r;
    pos_nxt  = pos_r;
    span_nxt = span_r;
    hold_nxt = hold_r;
    hit_nxt  = 1'b0;
    if (det_nxt == DET_WAIT && x_r < thr_r) begin
      trip_nxt = x_r;
      peak_nxt = '0;
      pos_nxt  = '0;
      span_nxt = '0;
      hold_nxt = release_time_r;
      det_nxt  = DET_TRIG;
    end
    if (det_nxt == DET_TRIG) begin
      // The trip sample is itself the first tracked sample.
      if (x_r < peak_nxt) begin
        peak_nxt = x_r;
        pos_nxt  = span_nxt;
      end
      if (span_nxt == peak_span_r) begin
        hit_nxt = 1'b1;
        det_nxt = DET_REL;
      end
      span_nxt = span_nxt + 1'b1;
    end
    if (det_nxt == DET_REL) begin
      if (hold_nxt == '0) begin
        det_nxt = DET_WAIT;
      end else begin
        hold_nxt = hold_nxt - 1'b1;
      end
    end
  end

  // The peak never lies above the trip value, so the drop fits in 15 bits.
  assign dist_c = trip_r - peak_r;

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_op.a = '0;
    mul_op.b = '0;
    case (state_r)
      S_MCOND: begin
        mul_op.a = {{14{diff_c[16]}}, diff_c};
        mul_op.b = input_gain_r;
      end
      S_MDD: begin
        mul_op.a = {16'd0, dist_c[14:0]};
        mul_op.b = {1'b0, dist_c[14:0]};
      end
      S_MVG: begin
        mul_op.a = {1'b0, prod_r[29:0]};
        mul_op.b = vel_gain_r;
      end
      S_MPP: begin
        mul_op.a = {23'd0, pos_r};
        mul_op.b = {8'd0, pos_r};
      end
      default: begin
        mul_op.a = '0;
        mul_op.b = '0;
      end
    endcase
  end

  // Velocity saturates when the quotient would need more than 15 bits.
  assign vel_sat = n2_r[30:15] >= prod_r[15:0];

  // Operand selection for the shared divider.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = phvd_pkg::DIV_NW'(hist_rsp.sum);
    div_req.divisor  = '0;
    if (state_r == S_SUM) begin
      div_req.start    = hist_rsp.done;
      div_req.dividend = phvd_pkg::DIV_NW'(hist_rsp.sum);
      div_req.divisor  = phvd_pkg::DIV_DW'(u_hist_count(avg_window_r));
    end else if (state_r == S_VCHK) begin
      div_req.start    = !vel_sat;
      div_req.dividend = n2_r;
      div_req.divisor  = prod_r[15:0];
    end
  end

  assign hist_req.push   = (state_r == S_COND);
  assign hist_req.mag    = mag_c;
  assign hist_req.window = avg_window_r;

  // Divisor of the average: the entries the history pass has just summed.
  logic [phvd_pkg::FILL_W-1:0] seen_r;

  function automatic logic [phvd_pkg::FILL_W-1:0] u_hist_count(input logic [7:0] window);
    logic [phvd_pkg::WCMP_W-1:0] w;
    logic [phvd_pkg::WCMP_W-1:0] wmax;
    wmax = phvd_pkg::WCMP_W'(phvd_pkg::MAX_WINDOW);
    w    = phvd_pkg::WCMP_W'(window);
    if (w == '0) begin
      w = phvd_pkg::WCMP_W'(1);
    end else if (w > wmax) begin
      w = wmax;
    end
    return (phvd_pkg::WCMP_W'(seen_r) < w) ? seen_r : phvd_pkg::FILL_W'(w);
  endfunction

  always_comb begin
    unique case (det_r)
      DET_WAIT: phase_c = phvd_pkg::PH_WAIT;
      DET_TRIG: phase_c = phvd_pkg::PH_TRIG;
      DET_REL:  phase_c = phvd_pkg::PH_REL;
      default:  phase_c = phvd_pkg::PH_WAIT;
    endcase
  end

  assign out_free = !out_tvalid_r || out_tready;
  assign loud_c   = hit_r && (vel_r >= loud_level_r);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      adc_offset_r   <= phvd_pkg::RST_ADC_OFFSET;
      input_gain_r   <= phvd_pkg::RST_INPUT_GAIN;
      thr_margin_r   <= phvd_pkg::RST_THR_MARGIN;
      avg_window_r   <= phvd_pkg::RST_AVG_WINDOW;
      peak_span_r    <= phvd_pkg::RST_PEAK_SPAN;
      release_time_r <= phvd_pkg::RST_RELEASE_TIME;
      vel_gain_r     <= phvd_pkg::RST_VEL_GAIN;
      loud_level_r   <= phvd_pkg::RST_LOUD_LEVEL;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        phvd_pkg::REG_ADC_OFFSET:   adc_offset_r   <= cfg_wdata;
        phvd_pkg::REG_INPUT_GAIN:   input_gain_r   <= cfg_wdata;
        phvd_pkg::REG_THR_MARGIN:   thr_margin_r   <= cfg_wdata[14:0];
        phvd_pkg::REG_AVG_WINDOW:   avg_window_r   <= cfg_wdata[7:0];
        phvd_pkg::REG_PEAK_SPAN:    peak_span_r    <= cfg_wdata[7:0];
        phvd_pkg::REG_RELEASE_TIME: release_time_r <= cfg_wdata;
        phvd_pkg::REG_VEL_GAIN:     vel_gain_r     <= cfg_wdata;
        phvd_pkg::REG_LOUD_LEVEL:   loud_level_r   <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer, detector state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      det_r        <= DET_WAIT;
      trip_r       <= '0;
      peak_r       <= '0;
      pos_r        <= '0;
      span_r       <= '0;
      hold_r       <= '0;
      seen_r       <= '0;
      hit_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      out_tuser_r  <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            raw_r   <= in_tdata;
            state_r <= S_MCOND;
          end
        end
        S_MCOND: begin
          state_r <= S_COND;
        end
        S_COND: begin
          // The history takes the new magnitude and starts summing the window.
          x_r     <= x_c;
          if (seen_r != phvd_pkg::FILL_W'(phvd_pkg::MAX_WINDOW)) begin
            seen_r <= seen_r + 1'b1;
          end
          state_r <= S_SUM;
        end
        S_SUM: begin
          if (hist_rsp.done) begin
            state_r <= S_ADIV;
          end
        end
        S_ADIV: begin
          if (div_rsp.done) begin
            thr_r   <= thr_c;
            state_r <= S_DET;
          end
        end
        S_DET: begin
          det_r  <= det_nxt;
          trip_r <= trip_nxt;
          peak_r <= peak_nxt;
          pos_r  <= pos_nxt;
          span_r <= span_nxt;
          hold_r <= hold_nxt;
          hit_r  <= hit_nxt;
          if (!hit_nxt) begin
            vel_r   <= '0;
            state_r <= S_OUT;
          end else if (pos_nxt == '0) begin
            // A peak on the trip sample itself means an infinitely steep edge.
            vel_r   <= phvd_pkg::VEL_FULL;
            state_r <= S_OUT;
          end else begin
            state_r <= S_MDD;
          end
        end
        S_MDD: begin
          state_r <= S_MVG;
        end
        S_MVG: begin
          state_r <= S_MPP;
        end
        S_MPP: begin
          // Dropping the low 15 bits first gives the same truncated quotient.
          n2_r    <= prod_r[45:15];
          state_r <= S_VCHK;
        end
        S_VCHK: begin
          if (vel_sat) begin
            vel_r   <= phvd_pkg::VEL_FULL;
            state_r <= S_OUT;
          end else begin
            state_r <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (div_rsp.done) begin
            vel_r   <= div_rsp.quot;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tuser_r  <= hit_r;
            out_tdata_r  <= {6'd0, phase_c, x_r, thr_r, loud_c, vel_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: rtl/phvd_mul.sv
// Shared signed-by-unsigned multiplier with a registered product.
module phvd_mul (
  input  logic                                    clk,
  input  phvd_pkg::mul_op_t                       op,
  output logic signed [phvd_pkg::PROD_W-1:0]      prod_r
);

  logic signed [phvd_pkg::PROD_W-1:0] prod_nxt;

  assign prod_nxt = $signed(op.a) * $signed({1'b0, op.b});

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// File: rtl/phvd_div.sv
// Restoring divider that yields one quotient bit per cycle for a 15-bit quotient.
module phvd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  phvd_pkg::div_req_t req,
  output phvd_pkg::div_rsp_t rsp
);

  logic [phvd_pkg::DIV_DW-1:0] rem_r;
  logic [phvd_pkg::DIV_QW-1:0] dvd_r;
  logic [phvd_pkg::DIV_QW-1:0] quot_r;
  logic [phvd_pkg::DIV_DW-1:0] dsr_r;
  logic [phvd_pkg::DIV_CW-1:0] cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [phvd_pkg::DIV_DW:0]   trial;
  logic [phvd_pkg::DIV_DW:0]   diff;
  logic                        fits;

  // The remainder stays below the divisor, so the shifted value fits in one more bit.
  assign trial = {rem_r, dvd_r[phvd_pkg::DIV_QW-1]};
  assign fits  = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= phvd_pkg::DIV_CW'(phvd_pkg::DIV_QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == phvd_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.dividend[phvd_pkg::DIV_NW-1:phvd_pkg::DIV_QW];
      dvd_r  <= req.dividend[phvd_pkg::DIV_QW-1:0];
      dsr_r  <= req.divisor;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= fits ? diff[phvd_pkg::DIV_DW-1:0] : trial[phvd_pkg::DIV_DW-1:0];
      dvd_r  <= {dvd_r[phvd_pkg::DIV_QW-2:0], 1'b0};
      quot_r <= {quot_r[phvd_pkg::DIV_QW-2:0], fits};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// File: rtl/phvd_hist.sv
// Circular history of absolute samples with a sequential sum over the newest entries.
module phvd_hist (
  input  logic                clk,
  input  logic                rst_n,
  input  phvd_pkg::hist_req_t req,
  output phvd_pkg::hist_rsp_t rsp
);

  logic [14:0]                    mem [phvd_pkg::MAX_WINDOW];
  logic [phvd_pkg::HIST_AW-1:0]   wp_r;
  logic [phvd_pkg::HIST_AW-1:0]   rd_ptr_r;
  logic [phvd_pkg::FILL_W-1:0]    fill_r;
  logic [phvd_pkg::FILL_W-1:0]    fill_nxt;
  logic [phvd_pkg::FILL_W-1:0]    left_r;
  logic [phvd_pkg::FILL_W-1:0]    count;
  logic [phvd_pkg::WCMP_W-1:0]    win_ext;
  logic [phvd_pkg::WCMP_W-1:0]    win_c;
  logic [14:0]                    rdata_r;
  logic                           rv_r;
  logic                           busy_r;
  logic                           done_r;
  logic [phvd_pkg::SUM_W-1:0]     sum_r;

  localparam logic [phvd_pkg::HIST_AW-1:0] LAST_IDX = phvd_pkg::HIST_AW'(phvd_pkg::MAX_WINDOW - 1);
  localparam logic [phvd_pkg::WCMP_W-1:0]  WIN_MAX  = phvd_pkg::WCMP_W'(phvd_pkg::MAX_WINDOW);

  always_comb begin
    fill_nxt = (fill_r == phvd_pkg::FILL_W'(phvd_pkg::MAX_WINDOW)) ? fill_r : fill_r + 1'b1;
    win_ext  = phvd_pkg::WCMP_W'(req.window);
    if (win_ext == '0) begin
      win_c = phvd_pkg::WCMP_W'(1);
    end else if (win_ext > WIN_MAX) begin
      win_c = WIN_MAX;
    end else begin
      win_c = win_ext;
    end
    count = (phvd_pkg::WCMP_W'(fill_nxt) < win_c) ? fill_nxt : phvd_pkg::FILL_W'(win_c);
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      mem[wp_r] <= req.mag;
    end
    rdata_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      left_r <= '0;
      rv_r   <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.push) begin
        // The newest entry goes in now and is read back first on the next cycle.
        wp_r     <= (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
        fill_r   <= fill_nxt;
        rd_ptr_r <= wp_r;
        left_r   <= count;
        rv_r     <= 1'b0;
        busy_r   <= 1'b1;
      end else if (busy_r) begin
        if (left_r != '0) begin
          rd_ptr_r <= (rd_ptr_r == '0) ? LAST_IDX : rd_ptr_r - 1'b1;
          left_r   <= left_r - 1'b1;
          rv_r     <= 1'b1;
        end else begin
          rv_r <= 1'b0;
          if (!rv_r) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.push) begin
      sum_r <= '0;
    end else if (rv_r) begin
      sum_r <= sum_r + phvd_pkg::SUM_W'(rdata_r);
    end
  end

  assign rsp.done = done_r;
  assign rsp.sum  = sum_r;

endmodule

// File: rtl/phvd_checker.sv
// Port-level checks of the piezo hit velocity detector and their binding.
module phvd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [phvd_pkg::OUT_DW-1:0] out_tdata,
  input logic                        out_tuser
);

  logic [1:0] phase;

  assign phase = out_tdata[phvd_pkg::PHASE_LSB+1:phvd_pkg::PHASE_LSB];

  // A request occupies the sequencer, so it never takes two in a row.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Velocity and loud are zero on results without a hit.
  a_quiet_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |->
      out_tdata[phvd_pkg::LOUD_BIT:phvd_pkg::VEL_LSB] == '0)
    else $error("velocity or loud set without a hit");

  a_phase_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> phase == phvd_pkg::PH_WAIT || phase == phvd_pkg::PH_TRIG ||
                   phase == phvd_pkg::PH_REL)
    else $error("phase code out of range");

  // A hit ends tracking, so the reported phase has left the triggered state.
  a_hit_leaves_trig: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> phase != phvd_pkg::PH_TRIG)
    else $error("hit reported while still triggered");

endmodule

bind piezo_hit_velocity_detector phvd_checker u_phvd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the piezo hit velocity detector stream block.
module tb_top;
  import phvd_pkg::*;

  // The slowest request is about 128 history reads, two divider passes and the velocity
  // products. Add the drawn input gaps and output stalls, and allow for about 1600
  // requests. The limit below leaves a wide margin over that.
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int TAIL_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 1500;

  // One result word as the block reports it, one per request.
  typedef struct {
    logic        hit;
    logic [14:0] velocity;
    logic        loud;
    logic [15:0] threshold;
    logic [15:0] conditioned;
    logic [1:0]  phase;
  } hit_report_t;

  // One row of the directed table: either a register write or a raw sample. For a
  // sample whose result can be worked out by hand, the result is typed into the row.
  typedef struct {
    bit          is_write;
    logic [2:0]  reg_idx;
    logic [15:0] value;
    bit          typed;
    hit_report_t report;
  } stim_row_t;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [15:0]         in_tdata   = '0;    // [15:0] raw_sample
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_DW-1:0]   out_tdata;          // [14:0] velocity, [15] loud, [31:16] threshold,
                                           // [47:32] conditioned, [49:48] phase, rest zero
  logic                out_tuser;          // [0] hit
  logic                cfg_we     = 1'b0;
  logic [2:0]          cfg_addr   = '0;
  logic [15:0]         cfg_wdata  = '0;

  piezo_hit_velocity_detector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies that the detector model works from. They follow each write.
  logic [15:0] c_offset  = RST_ADC_OFFSET;
  logic [15:0] c_gain    = RST_INPUT_GAIN;
  logic [14:0] c_margin  = RST_THR_MARGIN;
  logic [7:0]  c_window  = RST_AVG_WINDOW;
  logic [7:0]  c_span    = RST_PEAK_SPAN;
  logic [15:0] c_release = RST_RELEASE_TIME;
  logic [15:0] c_vgain   = RST_VEL_GAIN;
  logic [14:0] c_loud    = RST_LOUD_LEVEL;

  // Detector model state: magnitude history (newest first) and the trigger tracker.
  int          mag_hist [MAX_WINDOW];
  int          hist_fill = 0;
  logic [1:0]  det_phase = PH_WAIT;
  int          trip_lvl  = 0;
  int          peak_lvl  = 0;
  int          peak_at   = 0;
  int          span_cnt  = 0;
  int          hold_cnt  = 0;

  // Results that are owed by the block, oldest first.
  hit_report_t pending_reports[$];
  hit_report_t no_report;

  int  cycle_count   = 0;
  int  samples_sent  = 0;
  int  results_seen  = 0;
  int  hits_seen     = 0;
  int  mismatches    = 0;
  int  settings_used = 1;
  int  next_gap      = 0;
  bit  in_idle_on    = 1'b1;
  bit  out_idle_on   = 1'b1;

  // Conditions one raw sample, updates the moving average and steps the detector. It
  // returns the result word that the block must produce for this sample.
  function automatic hit_report_t predict_report(input logic [15:0] raw);
    longint            scaled;
    int                level, mag, win, n_avg, acc, avg, thr, k;
    longint unsigned   drop, num, den, quot;
    hit_report_t       r;
    // Offset and gain, then round half up: floor((x + 2^14) / 2^15).
    scaled = (longint'(raw) - longint'(c_offset)) * longint'(c_gain);
    scaled = (scaled + 64'sd16384) >>> 15;
    level  = (scaled > 32767) ? 32767 : (scaled < -32768) ? -32768 : int'(scaled);
    mag    = (level < 0) ? -level : level;
    if (mag > 32767) mag = 32767;
    for (k = MAX_WINDOW - 1; k > 0; k--) mag_hist[k] = mag_hist[k-1];
    mag_hist[0] = mag;
    if (hist_fill < MAX_WINDOW) hist_fill++;
    // A window of zero acts as one and anything past the memory depth as the depth.
    win = c_window;
    if (win < 1) win = 1;
    if (win > MAX_WINDOW) win = MAX_WINDOW;
    n_avg = (hist_fill < win) ? hist_fill : win;
    acc = 0;
    for (k = 0; k < n_avg; k++) acc += mag_hist[k];
    avg = acc / n_avg;
    thr = -avg - int'(c_margin);
    if (thr < -32768) thr = -32768;
    r.hit      = 1'b0;
    r.velocity = '0;
    r.loud     = 1'b0;
    if (det_phase == PH_WAIT && level < thr) begin
      trip_lvl  = level;
      peak_lvl  = 0;
      peak_at   = 0;
      span_cnt  = 0;
      hold_cnt  = c_release;
      det_phase = PH_TRIG;
    end
    if (det_phase == PH_TRIG) begin
      if (level < peak_lvl) begin
        peak_lvl = level;
        peak_at  = span_cnt;
      end
      if (span_cnt == c_span) begin
        r.hit = 1'b1;
        // A peak on the trip sample itself means an infinite slope: full scale.
        if (peak_at == 0) begin
          quot = 32767;
        end else begin
          drop = trip_lvl - peak_lvl;
          num  = drop * drop * c_vgain;
          den  = peak_at;
          den  = (den * den) << 15;
          quot = num / den;
          if (quot > 32767) quot = 32767;
        end
        r.velocity = quot[14:0];
        r.loud     = (quot >= c_loud);
        det_phase  = PH_REL;
      end
      span_cnt = (span_cnt + 1) & 255;
    end
    // The hit sample already counts as the first sample of the hold-off.
    if (det_phase == PH_REL) begin
      if (hold_cnt == 0) det_phase = PH_WAIT;
      else hold_cnt--;
    end
    r.threshold   = 16'(thr);
    r.conditioned = 16'(level);
    r.phase       = det_phase;
    return r;
  endfunction

  function automatic int idle_draw(input bit on);
    return on ? int'($urandom_range(0, 11)) : 0;
  endfunction

  // Keeps a synthesized sample inside the ADC code range.
  function automatic logic [15:0] near_raw(input int v);
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  // Mostly a value from the usual range, sometimes one of the two extremes.
  function automatic logic [15:0] pick(input int lo_ext, input int hi_ext,
                                       input int typ_lo, input int typ_hi);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 16'(lo_ext);
    if (roll == 1) return 16'(hi_ext);
    return 16'($urandom_range(typ_lo, typ_hi));
  endfunction

  function automatic stim_row_t reg_row(input logic [2:0] idx, input logic [15:0] val);
    stim_row_t r;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.value    = val;
    r.typed    = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t sample_row(input logic [15:0] raw);
    stim_row_t r;
    r.is_write = 1'b0;
    r.reg_idx  = '0;
    r.value    = raw;
    r.typed    = 1'b0;
    return r;
  endfunction

  function automatic stim_row_t known_row(input logic [15:0] raw, input logic hit,
                                          input logic [14:0] vel, input logic loud,
                                          input int thr, input int cond,
                                          input logic [1:0] ph);
    stim_row_t r;
    r = sample_row(raw);
    r.typed              = 1'b1;
    r.report.hit         = hit;
    r.report.velocity    = vel;
    r.report.loud        = loud;
    r.report.threshold   = 16'(thr);
    r.report.conditioned = 16'(cond);
    r.report.phase       = ph;
    return r;
  endfunction

  // Presents one request after the drawn gap and waits until the block takes it. The
  // valid stays high into the next request when that one has no gap, so it is never
  // lowered and raised within one time step.
  task automatic send_sample(input logic [15:0] raw, input bit typed,
                             input hit_report_t known);
    hit_report_t r;
    if (next_gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (next_gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= raw;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // The model steps on every accepted sample, even where the row carries a typed result.
    r = predict_report(raw);
    pending_reports.push_back(typed ? known : r);
    samples_sent++;
    next_gap = idle_draw(in_idle_on);
  endtask

  // Stops sending and waits until every owed result has been taken.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  // Drives one register write. The caller lowers the enable after a run of writes, so
  // back-to-back writes keep it high.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ADC_OFFSET:   c_offset  = val;
      REG_INPUT_GAIN:   c_gain    = val;
      REG_THR_MARGIN:   c_margin  = val[14:0];
      REG_AVG_WINDOW:   c_window  = val[7:0];
      REG_PEAK_SPAN:    c_span    = val[7:0];
      REG_RELEASE_TIME: c_release = val;
      REG_VEL_GAIN:     c_vgain   = val;
      REG_LOUD_LEVEL:   c_loud    = val[14:0];
      default: ;
    endcase
  endtask

  // Writes all eight registers for one random phase. The first phase holds the input
  // gain at zero with every other register at an extreme, so nothing trips while the
  // long release time is loaded. The second drives the conditioning into saturation
  // with a one-sample window, which trips on nearly every full-scale negative sample.
  task automatic configure_phase(input int which);
    logic [15:0] offset, gain, margin, window, span, hold, vgain, loud;
    case (which)
      0: begin
        offset = 16'hFFFF; gain = 16'd0;   margin = 16'd0;     window = 16'd255;
        span   = 16'd255;  hold = 16'hFFFF; vgain = 16'd0;     loud   = 16'd32767;
      end
      1: begin
        offset = 16'hFFFF; gain = 16'hFFFF; margin = 16'd0;    window = 16'd1;
        span   = 16'd0;    hold = 16'd0;    vgain = 16'hFFFF;  loud   = 16'd0;
      end
      default: begin
        offset = pick(0, 65535, 20000, 45000);
        gain   = pick(0, 65535, 8000, 40000);
        margin = pick(0, 32767, 0, 3000);
        window = pick(0, 255, 1, 128);
        span   = pick(0, 255, 1, 40);
        hold   = 16'($urandom_range(0, 60));
        vgain  = pick(0, 65535, 1, 2000);
        loud   = pick(0, 32767, 0, 32767);
      end
    endcase
    write_reg(REG_ADC_OFFSET, offset);
    write_reg(REG_INPUT_GAIN, gain);
    write_reg(REG_THR_MARGIN, margin);
    write_reg(REG_AVG_WINDOW, window);
    write_reg(REG_PEAK_SPAN, span);
    write_reg(REG_RELEASE_TIME, hold);
    write_reg(REG_VEL_GAIN, vgain);
    write_reg(REG_LOUD_LEVEL, loud);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // One strike as a piezo sees it: a quiet lead-in around the bias point, a fall to a
  // negative peak and a rise back with a little overshoot. Depth, slope and noise are
  // random, so some strikes trip the detector and some stay above the threshold.
  task automatic play_strike();
    int base, noise, depth, lead, fall, rise, k;
    base  = c_offset;
    noise = $urandom_range(0, 300);
    depth = $urandom_range(200, 40000);
    lead  = $urandom_range(2, 20);
    fall  = $urandom_range(1, 10);
    rise  = $urandom_range(1, 12);
    for (k = 0; k < lead; k++)
      send_sample(near_raw(base + int'($urandom_range(0, 2 * noise)) - noise), 1'b0,
                  no_report);
    for (k = 1; k <= fall; k++)
      send_sample(near_raw(base - depth * k / fall + int'($urandom_range(0, noise))),
                  1'b0, no_report);
    for (k = 1; k <= rise; k++)
      send_sample(near_raw(base - depth + depth * k / rise + ((k == rise) ? depth / 4 : 0)),
                  1'b0, no_report);
  endtask

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("tb_top: result %0d: %s", results_seen, msg);
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (act_v !== exp_v)
      note_failure($sformatf("%s expected 0x%0h, got 0x%0h", name, exp_v, act_v));
  endtask

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: no progress after %0d cycles", cycle_count);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Result side: stalls a drawn number of cycles before each result, then takes it and
  // compares every field with the oldest owed result.
  initial begin
    hit_report_t exp_r;
    int          stall;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_draw(out_idle_on);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_seen++;
      if (out_tuser === 1'b1) hits_seen++;
      if (pending_reports.size() == 0) begin
        note_failure("result arrived with no request outstanding");
      end else begin
        exp_r = pending_reports.pop_front();
        check_field("hit", exp_r.hit, out_tuser);
        check_field("velocity", exp_r.velocity, out_tdata[VEL_LSB +: 15]);
        check_field("loud", exp_r.loud, out_tdata[LOUD_BIT]);
        check_field("threshold", exp_r.threshold, out_tdata[THR_LSB +: 16]);
        check_field("conditioned", exp_r.conditioned, out_tdata[COND_LSB +: 16]);
        check_field("phase", exp_r.phase, out_tdata[PHASE_LSB +: 2]);
        check_field("padding", '0, out_tdata[OUT_DW-1:PHASE_LSB+2]);
      end
    end
  end

  // Request side: directed table first, then random phases, then the drain.
  initial begin
    stim_row_t plan[$];
    bit        writing;
    int        directed_count, phase_no, budget, start_count, burst, k;

    // Reset values: a sample at the bias point conditions to zero and leaves the
    // threshold at minus the margin.
    plan.push_back(known_row(RST_ADC_OFFSET, 1'b0, '0, 1'b0, -1638, 0, PH_WAIT));
    plan.push_back(sample_row(16'hFFFF));
    // Unity mapping: offset at mid-scale and a gain of one, so conditioned = raw - 32768.
    // One-sample window, no margin, hit on the trip sample and no hold-off.
    plan.push_back(reg_row(REG_ADC_OFFSET, 16'd32768));
    plan.push_back(reg_row(REG_INPUT_GAIN, 16'd32768));
    plan.push_back(reg_row(REG_THR_MARGIN, 16'd0));
    plan.push_back(reg_row(REG_AVG_WINDOW, 16'd1));
    plan.push_back(reg_row(REG_PEAK_SPAN, 16'd0));
    plan.push_back(reg_row(REG_RELEASE_TIME, 16'd0));
    plan.push_back(known_row(16'hFFFF, 1'b0, '0, 1'b0, -32767, 32767, PH_WAIT));
    // Negative full scale: the magnitude saturates at 32767, the sample is strictly
    // below the threshold, the peak sits at position zero and the velocity is full
    // scale. The detector rearms on the same sample.
    plan.push_back(known_row(16'h0000, 1'b1, VEL_FULL, 1'b1, -32767, -32768, PH_WAIT));
    plan.push_back(known_row(16'd32768, 1'b0, '0, 1'b0, 0, 0, PH_WAIT));
    // A sample equal to the threshold does not trip.
    plan.push_back(known_row(16'd32767, 1'b0, '0, 1'b0, -1, -1, PH_WAIT));
    // Largest margin with a zero window: the threshold saturates at the bottom and a
    // sample sitting on it does not trip.
    plan.push_back(reg_row(REG_THR_MARGIN, 16'd32767));
    plan.push_back(reg_row(REG_AVG_WINDOW, 16'd0));
    plan.push_back(reg_row(REG_VEL_GAIN, 16'd0));
    plan.push_back(reg_row(REG_LOUD_LEVEL, 16'd32767));
    plan.push_back(known_row(16'd32768, 1'b0, '0, 1'b0, -32767, 0, PH_WAIT));
    plan.push_back(known_row(16'd0, 1'b0, '0, 1'b0, -32768, -32768, PH_WAIT));
    // A clean strike with its peak three samples after the trip and a short hold-off.
    plan.push_back(reg_row(REG_INPUT_GAIN, 16'd16384));
    plan.push_back(reg_row(REG_THR_MARGIN, 16'd100));
    plan.push_back(reg_row(REG_AVG_WINDOW, 16'd2));
    plan.push_back(reg_row(REG_PEAK_SPAN, 16'd3));
    plan.push_back(reg_row(REG_RELEASE_TIME, 16'd2));
    plan.push_back(reg_row(REG_VEL_GAIN, 16'd1));
    plan.push_back(reg_row(REG_LOUD_LEVEL, 16'd0));
    plan.push_back(sample_row(16'd32768));
    plan.push_back(sample_row(16'd32768));
    plan.push_back(sample_row(16'd30000));
    plan.push_back(sample_row(16'd20000));
    plan.push_back(sample_row(16'd10000));
    plan.push_back(sample_row(16'd5000));
    plan.push_back(sample_row(16'd15000));
    plan.push_back(sample_row(16'd25000));
    for (k = 0; k < 4; k++) plan.push_back(sample_row(16'd32768));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    writing = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        if (!writing) begin
          wait_drained();
          writing = 1'b1;
          settings_used++;
        end
        write_reg(plan[i].reg_idx, plan[i].value);
      end else begin
        if (writing) begin
          cfg_we  <= 1'b0;
          writing = 1'b0;
        end
        send_sample(plan[i].value, plan[i].typed, plan[i].report);
      end
    end
    directed_count = samples_sent;

    // Random phases. Each phase gets a new register set and its own idling mode on both
    // sides, so some phases run back to back and others have gaps and stalls.
    phase_no = 0;
    while (samples_sent - directed_count < RANDOM_ITEMS) begin
      wait_drained();
      configure_phase(phase_no);
      in_idle_on  = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      budget      = (phase_no < 2) ? 60 : 130;
      start_count = samples_sent;
      while (samples_sent - start_count < budget) begin
        if ($urandom_range(0, 9) < 7) begin
          play_strike();
        end else begin
          burst = $urandom_range(1, 8);
          for (k = 0; k < burst; k++)
            send_sample(16'($urandom_range(0, 65535)), 1'b0, no_report);
        end
      end
      phase_no++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("tb_top: %0d samples sent (%0d directed) under %0d register settings",
             samples_sent, directed_count, settings_used);
    $display("tb_top: %0d results checked, %0d hits among them, %0d mismatches",
             results_seen, hits_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/phvd_pkg.sv
rtl/phvd_mul.sv
rtl/phvd_div.sv
rtl/phvd_hist.sv
rtl/piezo_hit_velocity_detector.sv
rtl/phvd_checker.sv
tb/sv/tb_top.sv
